### hdl/ssp_pkg.sv
// Package: shared constants, types and helpers of the size string parser.
`default_nettype none
package ssp_pkg;

   localparam int MAX_FRAC_DIGITS = 19;
   localparam int FRAC_LIMIT = (MAX_FRAC_DIGITS < 19) ? MAX_FRAC_DIGITS : 19;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_UNKNOWN_UNIT = 3'd1;
   localparam logic [2:0] STATUS_DECIMAL      = 3'd2;
   localparam logic [2:0] STATUS_INVALID      = 3'd3;
   localparam logic [2:0] STATUS_BAD_START    = 3'd4;
   localparam logic [2:0] STATUS_CONV_FAIL    = 3'd5;

   localparam logic [7:0] CHAR_DOT = 8'd46;
   localparam logic [7:0] CHAR_B   = 8'd66;
   localparam logic [7:0] CHAR_K   = 8'd75;
   localparam logic [7:0] CHAR_M   = 8'd77;
   localparam logic [7:0] CHAR_G   = 8'd71;

   localparam logic [4:0] SHIFT_NONE = 5'd0;
   localparam logic [4:0] SHIFT_KB   = 5'd10;
   localparam logic [4:0] SHIFT_MB   = 5'd20;
   localparam logic [4:0] SHIFT_GB   = 5'd30;

   localparam logic [63:0] INT_LIMIT = 64'd1844674407370955161;
   localparam logic [63:0] SIZE_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic take;
      logic finish;
      logic step;
      logic deliver;
   } ssp_cmd_type;

   typedef struct packed {
      logic scale_done;
   } ssp_stat_type;

   function automatic logic [63:0] pow_ten(input logic [4:0] n);
      logic [63:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         default: p = 64'd10000000000000000000;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

### hdl/ssp_if.sv
// Interfaces: character request channel and size response channel.
`default_nettype none
interface ssp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink (input valid, input character, input last_char, output ready);
endinterface

interface ssp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] byte_count;
   logic [2:0]  status;

   modport source (output valid, output byte_count, output status, input ready);
   modport sink (input valid, input byte_count, input status, output ready);
endinterface
`default_nettype wire

### hdl/ssp_ctrl.sv
// Controller: sequences character intake, finishing, scaling and result hand-off.
`default_nettype none
module ssp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ssp_pkg::ssp_stat_type stat,
   output ssp_pkg::ssp_cmd_type      cmd
);

   typedef enum logic [1:0] {S_ACCEPT, S_FINISH, S_SCALE, S_DONE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.take    = req_valid && (state_ff == S_ACCEPT);
      cmd.finish  = (state_ff == S_FINISH);
      cmd.step    = (state_ff == S_SCALE) && !stat.scale_done;
      cmd.deliver = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      case (state_ff)
         S_ACCEPT: begin
            if (cmd.take && req_last) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_SCALE;
         S_SCALE: begin
            if (stat.scale_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd.deliver) state_in = S_ACCEPT;
         end
         default: state_in = S_ACCEPT;
      endcase

      if (cmd.deliver) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_ACCEPT);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### hdl/ssp_datapath.sv
// Datapath: parse state, finishing decode, bit-serial fraction scaler, result register.
`default_nettype none
module ssp_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssp_pkg::ssp_cmd_type cmd,
   input  wire logic [7:0]           character,
   output ssp_pkg::ssp_stat_type     stat,
   output logic [63:0]               byte_count,
   output logic [2:0]                status
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_INT, PH_FRAC, PH_GAP, PH_UNIT, PH_BAD, PH_FAIL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] int_ff, int_in;
   logic [63:0] frac_ff, frac_in;
   logic [4:0]  fcnt_ff, fcnt_in;
   logic        dot_ff, dot_in;
   logic [7:0]  uchar0_ff, uchar0_in;
   logic [7:0]  uchar1_ff, uchar1_in;
   logic [1:0]  ulen_ff, ulen_in;
   logic        spend_ff, spend_in;
   logic        pinv_ff, pinv_in;
   logic        ovf_ff, ovf_in;

   logic [63:0] base_ff, base_in;
   logic [2:0]  code_ff, code_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [4:0]  iter_ff, iter_in;
   logic [29:0] bits_ff, bits_in;
   logic [63:0] byte_count_ff, byte_count_in;
   logic [2:0]  status_ff, status_in;

   logic        numeral, is_blank, unit_add;
   logic [3:0]  digit;
   logic [4:0]  shift;
   logic        too_big, scaling;
   logic [63:0] den_f;
   logic [64:0] twice;
   logic        ge;

   assign numeral  = character inside {[8'd48:8'd57]};
   assign is_blank = character inside {8'd32, [8'd9:8'd13]};
   assign digit    = character[3:0];

   // character intake and clear on finish
   always_comb begin
      phase_in  = phase_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      fcnt_in   = fcnt_ff;
      dot_in    = dot_ff;
      uchar0_in = uchar0_ff;
      uchar1_in = uchar1_ff;
      ulen_in   = ulen_ff;
      spend_in  = spend_ff;
      pinv_in   = pinv_ff;
      ovf_in    = ovf_ff;
      unit_add  = 1'b0;

      if (cmd.take) begin
         if ((phase_ff == PH_LEAD || phase_ff == PH_INT) && numeral && !ovf_ff) begin
            if (int_ff > ssp_pkg::INT_LIMIT ||
                (int_ff == ssp_pkg::INT_LIMIT && digit > 4'd5)) begin
               ovf_in = 1'b1;
               int_in = ssp_pkg::SIZE_MAX;
            end else begin
               int_in = (int_ff << 3) + (int_ff << 1) + {60'd0, digit};
            end
         end
         case (phase_ff)
            PH_LEAD: begin
               if (numeral) phase_in = PH_INT;
               else if (character == ssp_pkg::CHAR_DOT) begin
                  dot_in   = 1'b1;
                  phase_in = PH_FRAC;
               end else if (!is_blank) phase_in = PH_BAD;
            end
            PH_INT: begin
               if (character == ssp_pkg::CHAR_DOT) begin
                  dot_in   = 1'b1;
                  phase_in = PH_FRAC;
               end else if (!numeral) begin
                  pinv_in = 1'b1;
                  if (is_blank) phase_in = PH_GAP;
                  else unit_add = 1'b1;
               end
            end
            PH_FRAC: begin
               if (numeral) begin
                  if (fcnt_ff < 5'(ssp_pkg::FRAC_LIMIT)) begin
                     frac_in = (frac_ff << 3) + (frac_ff << 1) + {60'd0, digit};
                     fcnt_in = fcnt_ff + 5'd1;
                  end
               end else if (is_blank) phase_in = PH_GAP;
               else unit_add = 1'b1;
            end
            PH_GAP, PH_UNIT: begin
               if (character == ssp_pkg::CHAR_DOT && !dot_ff && pinv_ff) phase_in = PH_FAIL;
               else if (is_blank) begin
                  if (phase_ff == PH_UNIT) spend_in = 1'b1;
               end else unit_add = 1'b1;
            end
            default: ;
         endcase
         if (unit_add) begin
            if (spend_ff && ulen_ff != 2'd0) ulen_in = 2'd3;
            else begin
               if (ulen_ff == 2'd0) uchar0_in = character;
               else if (ulen_ff == 2'd1) uchar1_in = character;
               if (ulen_ff != 2'd3) ulen_in = ulen_ff + 2'd1;
            end
            spend_in = 1'b0;
            phase_in = PH_UNIT;
         end
      end

      if (cmd.finish) begin
         phase_in  = PH_LEAD;
         int_in    = 64'd0;
         frac_in   = 64'd0;
         fcnt_in   = 5'd0;
         dot_in    = 1'b0;
         uchar0_in = 8'd0;
         uchar1_in = 8'd0;
         ulen_in   = 2'd0;
         spend_in  = 1'b0;
         pinv_in   = 1'b0;
         ovf_in    = 1'b0;
      end
   end

   // finishing decode and scaler
   always_comb begin
      shift = ssp_pkg::SHIFT_NONE;
      if (ulen_ff == 2'd2 && uchar1_ff == ssp_pkg::CHAR_B) begin
         if (uchar0_ff == ssp_pkg::CHAR_K) shift = ssp_pkg::SHIFT_KB;
         else if (uchar0_ff == ssp_pkg::CHAR_M) shift = ssp_pkg::SHIFT_MB;
         else if (uchar0_ff == ssp_pkg::CHAR_G) shift = ssp_pkg::SHIFT_GB;
      end

      case (shift)
         ssp_pkg::SHIFT_KB: too_big = (int_ff[63:54] != 10'd0);
         ssp_pkg::SHIFT_MB: too_big = (int_ff[63:44] != 20'd0);
         ssp_pkg::SHIFT_GB: too_big = (int_ff[63:34] != 30'd0);
         default:           too_big = 1'b0;
      endcase

      scaling = (phase_ff == PH_UNIT) && (shift != ssp_pkg::SHIFT_NONE) && !ovf_ff && !too_big;

      base_in = 64'd0;
      code_in = ssp_pkg::STATUS_OK;
      case (phase_ff)
         PH_LEAD: ;
         PH_BAD:  code_in = ssp_pkg::STATUS_BAD_START;
         PH_FAIL: code_in = ssp_pkg::STATUS_CONV_FAIL;
         PH_INT, PH_GAP, PH_FRAC: begin
            if (!dot_ff) begin
               if (ovf_ff) code_in = ssp_pkg::STATUS_CONV_FAIL;
               else base_in = int_ff;
            end else begin
               code_in = ssp_pkg::STATUS_DECIMAL;
               base_in = int_ff;
            end
         end
         PH_UNIT: begin
            if (ulen_ff >= 2'd2) begin
               if (shift == ssp_pkg::SHIFT_NONE) code_in = ssp_pkg::STATUS_UNKNOWN_UNIT;
            end else if (dot_ff) code_in = ssp_pkg::STATUS_DECIMAL;
            else code_in = ssp_pkg::STATUS_INVALID;
            if (ovf_ff || too_big) base_in = ssp_pkg::SIZE_MAX;
            else begin
               case (shift)
                  ssp_pkg::SHIFT_KB: base_in = {int_ff[53:0], 10'd0};
                  ssp_pkg::SHIFT_MB: base_in = {int_ff[43:0], 20'd0};
                  ssp_pkg::SHIFT_GB: base_in = {int_ff[33:0], 30'd0};
                  default:           base_in = int_ff;
               endcase
            end
         end
         default: ;
      endcase

      den_f = ssp_pkg::pow_ten(fcnt_ff);
      twice = {rem_ff, 1'b0};
      ge    = (twice >= {1'b0, den_ff});

      rem_in  = rem_ff;
      den_in  = den_ff;
      iter_in = iter_ff;
      bits_in = bits_ff;
      if (cmd.finish) begin
         den_in  = den_f;
         rem_in  = (frac_ff >= den_f) ? den_f - 64'd1 : frac_ff;
         iter_in = scaling ? shift : 5'd0;
         bits_in = 30'd0;
      end else if (cmd.step) begin
         rem_in  = ge ? 64'(twice - {1'b0, den_ff}) : twice[63:0];
         iter_in = iter_ff - 5'd1;
         bits_in = {bits_ff[28:0], ge};
      end

      if (!cmd.finish) begin
         base_in = base_ff;
         code_in = code_ff;
      end

      byte_count_in = byte_count_ff;
      status_in     = status_ff;
      if (cmd.deliver) begin
         byte_count_in = base_ff | {34'd0, bits_ff};
         status_in     = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         int_ff    <= 64'd0;
         frac_ff   <= 64'd0;
         fcnt_ff   <= 5'd0;
         dot_ff    <= 1'b0;
         uchar0_ff <= 8'd0;
         uchar1_ff <= 8'd0;
         ulen_ff   <= 2'd0;
         spend_ff  <= 1'b0;
         pinv_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         iter_ff   <= 5'd0;
      end else begin
         phase_ff  <= phase_in;
         int_ff    <= int_in;
         frac_ff   <= frac_in;
         fcnt_ff   <= fcnt_in;
         dot_ff    <= dot_in;
         uchar0_ff <= uchar0_in;
         uchar1_ff <= uchar1_in;
         ulen_ff   <= ulen_in;
         spend_ff  <= spend_in;
         pinv_ff   <= pinv_in;
         ovf_ff    <= ovf_in;
         iter_ff   <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      code_ff       <= code_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      bits_ff       <= bits_in;
      byte_count_ff <= byte_count_in;
      status_ff     <= status_in;
   end

   assign stat.scale_done = (iter_ff == 5'd0);
   assign byte_count      = byte_count_ff;
   assign status          = status_ff;

endmodule
`default_nettype wire

### hdl/size_string_parser.sv
// Top level: size string parser, controller plus datapath behind valid/ready channels.
// Flow: after the last character the controller passes through its finish, scale and done
//   states; the scaler runs only for a scaled KB, MB or GB unit; delivery registers the result.
// Throughput: one character per cycle while accepting; after a last character the next one waits
//   for finish, the one-bit-per-cycle scaler and delivery, longer while an earlier result is unread.
// Reset: synchronous, active high; clears parse and control state, no clearing pass.
`default_nettype none
module size_string_parser (
   input wire logic   clock,
   input wire logic   reset,
   ssp_req_if.sink    req_chan,
   ssp_rsp_if.source  rsp_chan
);

   ssp_pkg::ssp_cmd_type  cmd;
   ssp_pkg::ssp_stat_type stat;

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_char),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .character  (req_chan.character),
      .stat       (stat),
      .byte_count (rsp_chan.byte_count),
      .status     (rsp_chan.status)
   );

   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten while a transaction is pending");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ssp_pkg::STATUS_BAD_START ||
                          rsp_chan.status == ssp_pkg::STATUS_CONV_FAIL))
      |-> (rsp_chan.byte_count == 64'd0))
      else $error("non-zero byte count on a failed parse");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !stat.scale_done)
      else $error("scaler stepped with no iterations left");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !req_chan.ready)
      else $error("character accepted while finishing");

endmodule
`default_nettype wire
